[rtl/ptq_pkg.sv]
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the periodic timer queue
// Command and status codes, transaction structs and the sequencer states.
// ----------------------------------------------------------------------------
package ptq_pkg;

   localparam int MAX_TIMERS   = 16;
   localparam int ID_W         = 4;
   localparam int CNT_W        = 5;
   localparam int TIME_WIDTH   = 48;
   localparam int PERIOD_W     = 31;
   localparam int MIN_W        = 16;
   localparam logic [MIN_W-1:0] MIN_RESET = 16'd5;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FIRED    = 3'd1,
      ST_TOOSMALL = 3'd2,
      ST_FULL     = 3'd3,
      ST_RELEASED = 3'd4,
      ST_UNKNOWN  = 3'd5,
      ST_CLEARED  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INS, S_FIRE, S_REARM, S_FIND, S_DEL, S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [PERIOD_W-1:0]   interval_ms;
      logic [TIME_WIDTH-1:0] now_ms;
      logic [ID_W-1:0]       target_id;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] slot_id;
      logic            last;
   } rsp_type;

endpackage

[rtl/ptq_front.sv]
// ----------------------------------------------------------------------------
// ptq_front: command queue
// Two-entry queue that takes request transactions and hands them to the back.
// ----------------------------------------------------------------------------
module ptq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptq_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output ptq_pkg::req_type pop_data,
   output logic             empty
);

   ptq_pkg::req_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/ptq_rsp_queue.sv]
// ----------------------------------------------------------------------------
// ptq_rsp_queue: result queue
// Four-entry queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module ptq_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptq_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output ptq_pkg::rsp_type pop_data,
   output logic             empty
);

   ptq_pkg::rsp_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/ptq_back.sv]
// ----------------------------------------------------------------------------
// ptq_back: timer table sequencer
// Holds the timer table and the deadline-ordered list and carries out one
// command at a time: sorted insertion one compare per cycle, expiry from the
// head of the list, release by scan and shift.
// ----------------------------------------------------------------------------
module ptq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [ptq_pkg::MIN_W-1:0]    csr_wdata,
   input  logic                         cmd_empty,
   input  ptq_pkg::req_type             cmd_data,
   output logic                         cmd_pop,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output ptq_pkg::rsp_type             rsp_data
);

   localparam int N  = ptq_pkg::MAX_TIMERS;
   localparam int IW = ptq_pkg::ID_W;
   localparam int CW = ptq_pkg::CNT_W;
   localparam int TW = ptq_pkg::TIME_WIDTH;
   localparam int PW = ptq_pkg::PERIOD_W;

   ptq_pkg::state_type state_ff, state_in;

   logic [TW-1:0]  deadline_ff [N];
   logic [PW-1:0]  period_ff   [N];
   logic [IW-1:0]  order_ff    [N];
   logic [IW-1:0]  fired_ff    [N];
   logic [N-1:0]   valid_ff, valid_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [ptq_pkg::MIN_W-1:0] min_ff;

   ptq_pkg::req_type cur_ff, cur_in;
   ptq_pkg::rsp_type pend_ff, pend_in;
   logic           has_pend_ff, has_pend_in;
   logic           ret_rearm_ff, ret_rearm_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  nf_ff, nf_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [IW-1:0]  ins_slot_ff, ins_slot_in;

   // write strobes for the table
   logic           dl_we, per_we;
   logic [IW-1:0]  dl_addr;
   logic [TW-1:0]  dl_data;
   logic           ord_we, ord_shift;
   logic [IW-1:0]  ord_addr, ord_data;
   logic           fired_we;

   logic [IW-1:0]  free_slot;
   logic [TW:0]    arm_sum;
   logic [TW-1:0]  arm_val;
   logic [PW-1:0]  arm_per;
   logic [IW-1:0]  prev_slot, head_slot, rearm_slot;
   logic           head_due;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (!valid_ff[k]) free_slot = IW'(k);
      end
   end

   // arm time, saturating
   assign rearm_slot = fired_ff[j_ff[IW-1:0]];
   assign arm_per    = (state_ff == ptq_pkg::S_IDLE) ? cmd_data.interval_ms
                                                      : period_ff[rearm_slot];
   assign arm_sum    = {1'b0, (state_ff == ptq_pkg::S_IDLE) ? cmd_data.now_ms : cur_ff.now_ms}
                       + {{(TW + 1 - PW){1'b0}}, arm_per};
   assign arm_val    = arm_sum[TW] ? {TW{1'b1}} : arm_sum[TW-1:0];

   assign prev_slot  = order_ff[IW'(idx_ff - CW'(1))];
   assign head_slot  = order_ff[0];
   assign head_due   = (nf_ff != CW'(N)) && (count_ff != '0)
                       && (deadline_ff[head_slot] <= cur_ff.now_ms);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptq_pkg::S_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         has_pend_ff <= 1'b0;
         min_ff      <= ptq_pkg::MIN_RESET;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         has_pend_ff <= has_pend_in;
         if (csr_we) min_ff <= csr_wdata;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pend_ff      <= pend_in;
      ret_rearm_ff <= ret_rearm_in;
      idx_ff       <= idx_in;
      nf_ff        <= nf_in;
      j_ff         <= j_in;
      ins_slot_ff  <= ins_slot_in;
   end

   // table storage
   always_ff @(posedge clock) begin
      if (dl_we) deadline_ff[dl_addr] <= dl_data;
      if (per_we) period_ff[dl_addr] <= cur_in.interval_ms;
      if (fired_we) fired_ff[nf_ff[IW-1:0]] <= head_slot;
      if (ord_shift) begin
         for (int k = 0; k < N - 1; k++) order_ff[k] <= order_ff[k + 1];
      end else if (ord_we) begin
         order_ff[ord_addr] <= ord_data;
      end
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      has_pend_in  = has_pend_ff;
      ret_rearm_in = ret_rearm_ff;
      idx_in       = idx_ff;
      nf_in        = nf_ff;
      j_in         = j_ff;
      ins_slot_in  = ins_slot_ff;
      dl_we        = 1'b0;
      per_we       = 1'b0;
      dl_addr      = ins_slot_ff;
      dl_data      = arm_val;
      ord_we       = 1'b0;
      ord_shift    = 1'b0;
      ord_addr     = idx_ff[IW-1:0];
      ord_data     = ins_slot_ff;
      fired_we     = 1'b0;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = pend_ff;
      case (state_ff)
         ptq_pkg::S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_data;
               pend_in = '{status: ptq_pkg::ST_CLEARED, slot_id: '0, last: 1'b1};
               case (cmd_data.cmd)
                  ptq_pkg::CMD_ADD: begin
                     if (cmd_data.interval_ms < {{(PW - ptq_pkg::MIN_W){1'b0}}, min_ff}) begin
                        pend_in.status = ptq_pkg::ST_TOOSMALL;
                        state_in = ptq_pkg::S_EMIT;
                     end else if (count_ff == CW'(N)) begin
                        pend_in.status = ptq_pkg::ST_FULL;
                        state_in = ptq_pkg::S_EMIT;
                     end else begin
                        pend_in.status  = ptq_pkg::ST_ADDED;
                        pend_in.slot_id = free_slot;
                        valid_in[free_slot] = 1'b1;
                        dl_we        = 1'b1;
                        per_we       = 1'b1;
                        dl_addr      = free_slot;
                        ins_slot_in  = free_slot;
                        idx_in       = count_ff;
                        ret_rearm_in = 1'b0;
                        state_in     = ptq_pkg::S_INS;
                     end
                  end
                  ptq_pkg::CMD_TICK: begin
                     nf_in       = '0;
                     has_pend_in = 1'b0;
                     state_in    = ptq_pkg::S_FIRE;
                  end
                  ptq_pkg::CMD_RELEASE: begin
                     pend_in.slot_id = cmd_data.target_id;
                     idx_in = '0;
                     if (valid_ff[cmd_data.target_id]) begin
                        state_in = ptq_pkg::S_FIND;
                     end else begin
                        pend_in.status = ptq_pkg::ST_UNKNOWN;
                        state_in = ptq_pkg::S_EMIT;
                     end
                  end
                  default: begin
                     valid_in = '0;
                     count_in = '0;
                     state_in = ptq_pkg::S_EMIT;
                  end
               endcase
            end
         end
         // walk down from the tail, shifting later deadlines up one place
         ptq_pkg::S_INS: begin
            if (idx_ff != '0 && deadline_ff[prev_slot] > deadline_ff[ins_slot_ff]) begin
               ord_we   = 1'b1;
               ord_data = prev_slot;
               idx_in   = idx_ff - CW'(1);
            end else begin
               ord_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ret_rearm_ff ? ptq_pkg::S_REARM : ptq_pkg::S_EMIT;
            end
         end
         // pop due timers from the head; hold back one result to mark last
         ptq_pkg::S_FIRE: begin
            if (head_due) begin
               if (!has_pend_ff || !rsp_full) begin
                  rsp_push       = has_pend_ff;
                  rsp_data.last  = 1'b0;
                  pend_in        = '{status: ptq_pkg::ST_FIRED, slot_id: head_slot,
                                     last: 1'b1};
                  has_pend_in    = 1'b1;
                  fired_we       = 1'b1;
                  ord_shift      = 1'b1;
                  count_in       = count_ff - CW'(1);
                  nf_in          = nf_ff + CW'(1);
               end
            end else if (!has_pend_ff) begin
               state_in = ptq_pkg::S_IDLE;
            end else if (!rsp_full) begin
               rsp_push    = 1'b1;
               has_pend_in = 1'b0;
               j_in        = '0;
               state_in    = ptq_pkg::S_REARM;
            end
         end
         // re-arm fired timers in firing order and insert each sorted
         ptq_pkg::S_REARM: begin
            if (j_ff == nf_ff) begin
               state_in = ptq_pkg::S_IDLE;
            end else begin
               dl_we        = 1'b1;
               dl_addr      = rearm_slot;
               ins_slot_in  = rearm_slot;
               idx_in       = count_ff;
               ret_rearm_in = 1'b1;
               j_in         = j_ff + CW'(1);
               state_in     = ptq_pkg::S_INS;
            end
         end
         // search the list for the slot to release
         ptq_pkg::S_FIND: begin
            if (idx_ff == count_ff) begin
               valid_in[cur_ff.target_id] = 1'b0;
               pend_in.status = ptq_pkg::ST_UNKNOWN;
               state_in = ptq_pkg::S_EMIT;
            end else if (order_ff[idx_ff[IW-1:0]] == cur_ff.target_id) begin
               state_in = ptq_pkg::S_DEL;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         // close the gap one entry a cycle
         ptq_pkg::S_DEL: begin
            if (idx_ff + CW'(1) < count_ff) begin
               ord_we   = 1'b1;
               ord_data = order_ff[IW'(idx_ff + CW'(1))];
               idx_in   = idx_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               valid_in[cur_ff.target_id] = 1'b0;
               pend_in.status = ptq_pkg::ST_RELEASED;
               state_in = ptq_pkg::S_EMIT;
            end
         end
         ptq_pkg::S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ptq_pkg::S_IDLE;
            end
         end
         default: state_in = ptq_pkg::S_IDLE;
      endcase
   end

endmodule

[rtl/periodic_timer_queue.sv]
// ----------------------------------------------------------------------------
// periodic_timer_queue: sorted deadline timer table
// Top level: command queue, table sequencer and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the req_ queue port (push/full): add, tick, release,
//   clear. Results leave on the rsp_ queue port (empty/pop); every command
//   gives one result except a tick, which gives one per fired timer (none
//   when nothing is due). The last result of a command carries rsp_last.
//   csr_we/csr_wdata write the minimum interval (reset value 5).
// Timing:
//   A two-entry command queue takes transactions while the sequencer works.
//   An accepted add inserts the new timer with one deadline compare per cycle.
//   Release answers an invalid slot without a scan; else it scans the list,
//   then shifts one entry per cycle to close the gap.
//   A tick first pops the due timers from the head of the list, then
//   re-inserts each one with the single-compare insertion loop.
// Reset:
//   Reset empties the table and both queues and restores the minimum.
// Stall:
//   When the result side does not pop, the four-entry result queue fills,
//   the sequencer holds, and then full rises on the command side.
// ----------------------------------------------------------------------------
module periodic_timer_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [1:0]                        req_cmd,
   input  logic [ptq_pkg::PERIOD_W-1:0]      req_interval_ms,
   input  logic [ptq_pkg::TIME_WIDTH-1:0]    req_now_ms,
   input  logic [ptq_pkg::ID_W-1:0]          req_target_id,
   output logic                              empty,
   input  logic                              pop,
   output logic [2:0]                        rsp_status,
   output logic [ptq_pkg::ID_W-1:0]          rsp_slot_id,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [ptq_pkg::MIN_W-1:0]         csr_wdata
);

   ptq_pkg::req_type req_data, cmd_data;
   ptq_pkg::rsp_type seq_rsp, out_rsp;
   logic cmd_empty, cmd_pop, rsp_full, rsp_push;

   assign req_data = '{cmd: req_cmd, interval_ms: req_interval_ms,
                       now_ms: req_now_ms, target_id: req_target_id};

   ptq_front u_front (
      .clock(clock), .reset(reset),
      .push(push), .push_data(req_data), .full(full),
      .pop(cmd_pop), .pop_data(cmd_data), .empty(cmd_empty)
   );

   ptq_back u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd_empty(cmd_empty), .cmd_data(cmd_data), .cmd_pop(cmd_pop),
      .rsp_full(rsp_full), .rsp_push(rsp_push), .rsp_data(seq_rsp)
   );

   ptq_rsp_queue u_rsp (
      .clock(clock), .reset(reset),
      .push(rsp_push), .push_data(seq_rsp), .full(rsp_full),
      .pop(pop), .pop_data(out_rsp), .empty(empty)
   );

   assign rsp_status  = out_rsp.status;
   assign rsp_slot_id = out_rsp.slot_id;
   assign rsp_last    = out_rsp.last;

endmodule

[rtl/ptq_checker.sv]
// ----------------------------------------------------------------------------
// ptq_checker: port-level checks of the timer queue
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ptq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       empty,
   input logic                       pop,
   input logic [2:0]                 rsp_status,
   input logic [ptq_pkg::ID_W-1:0]   rsp_slot_id,
   input logic                       rsp_last
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // hold a waiting result while not popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_slot_id) && $stable(rsp_status)))
      else $error("waiting result changed");

   // only fired results may be non-final
   a_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != ptq_pkg::ST_FIRED) |-> rsp_last)
      else $error("single result without last");

   // refused and cleared results name slot zero
   a_slot0: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status == ptq_pkg::ST_TOOSMALL || rsp_status == ptq_pkg::ST_FULL
                  || rsp_status == ptq_pkg::ST_CLEARED))
      |-> (rsp_slot_id == '0))
      else $error("refused or cleared result with nonzero slot");

endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop),
   .rsp_status(rsp_status), .rsp_slot_id(rsp_slot_id), .rsp_last(rsp_last)
);
